// ----- rtl/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, codes and controller/datapath interface types for the
// text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int MAX_COLUMNS = 80;
    localparam int MAX_ROWS    = 25;
    localparam int CELL_COUNT  = MAX_ROWS * MAX_COLUMNS;

    // field and register widths
    localparam int COLS_W = 7;
    localparam int ROWS_W = 5;
    localparam int IDX_W  = $clog2(CELL_COUNT);
    localparam int AREA_W = COLS_W + ROWS_W;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CELL_W = CHAR_W + ATTR_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // opcodes
    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_ATTR = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ERROR_ATTR  = 2'd3;

    // reset values
    localparam logic [COLS_W-1:0] RST_COLUMNS     = 7'd80;
    localparam logic [ROWS_W-1:0] RST_ROWS        = 5'd25;
    localparam logic [ATTR_W-1:0] RST_NORMAL_ATTR = 8'h07;
    localparam logic [ATTR_W-1:0] RST_ERROR_ATTR  = 8'h04;

    // characters
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    typedef enum logic [4:0] {
        ST_INIT   = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_READ   = 5'b00100,
        ST_SCROLL = 5'b01000,
        ST_CLEAR  = 5'b10000
    } state_t;

    typedef struct packed {
        logic accept;       // transaction taken this cycle
        logic fill;         // blanking sweep step
        logic fill_init;    // blanking uses the reset attribute
        logic scroll;       // scroll sweep step
        logic load_out;     // load result register
        logic out_read;     // result carries read data
        logic out_scrolled; // result reports a scroll
    } cmd_t;

    typedef struct packed {
        logic op_clear;
        logic op_read;
        logic put_scroll;
        logic fill_last;
        logic scroll_last;
    } status_t;

endpackage

// ----- rtl/text_console_writer_top.sv -----
// ----------------------------------------------------------------------------
// text_console_writer_top
// Character-cell text console writer with a 2000-cell screen memory.
// ----------------------------------------------------------------------------
// Input channel s_*: one transaction per command (put, clear, read). Result
// channel m_*: one transaction per command, carrying the read cell (zero for
// other commands), the cursor after the command and the scroll flag.
// Configuration: cfg_wr_en/cfg_index/cfg_wdata write columns, rows,
// normal_attr, error_attr; columns and rows home the cursor.
// Results: a put without scroll, or an unused opcode, presents its result
// in the cycle after acceptance; a read passes through the registered memory
// read and then the result register. A scroll sweeps the area in use through
// the single memory write port, copying and blanking one cell a cycle. A
// clear blanks every cell.
// Throughput: one command at a time; a put follows every cycle while the
// result register drains.
// Reset: a blanking pass writes space with attribute 0x07 to every cell;
// s_ready stays low meanwhile, configuration writes are taken.
// Stall: while a result waits on m_ready, the result register holds and no
// further command is accepted.
// ----------------------------------------------------------------------------
module text_console_writer_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tcw_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [1:0]                         s_opcode,
    input  logic [tcw_pkg::CHAR_W-1:0]         s_char_code,
    input  logic                               s_to_error_stream,
    input  logic [tcw_pkg::IDX_W-1:0]          s_cell_index,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [tcw_pkg::CHAR_W-1:0]         m_cell_char,
    output logic [tcw_pkg::ATTR_W-1:0]         m_cell_attr,
    output logic [tcw_pkg::IDX_W-1:0]          m_cursor_index,
    output logic                               m_scrolled
);

    tcw_pkg::cmd_t    cmd;
    tcw_pkg::status_t st;

    tcw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .st      (st),
        .cmd     (cmd)
    );

    tcw_dp u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_opcode          (s_opcode),
        .s_char_code       (s_char_code),
        .s_to_error_stream (s_to_error_stream),
        .s_cell_index      (s_cell_index),
        .m_cell_char       (m_cell_char),
        .m_cell_attr       (m_cell_attr),
        .m_cursor_index    (m_cursor_index),
        .m_scrolled        (m_scrolled),
        .cmd               (cmd),
        .st                (st)
    );

endmodule

// ----- rtl/tcw_ctrl.sv -----
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer: handshakes, reset blanking pass, read, scroll and clear sweeps.
// ----------------------------------------------------------------------------
module tcw_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    input  tcw_pkg::status_t st,
    output tcw_pkg::cmd_t   cmd
);

    tcw_pkg::state_t state_reg, state_next;
    logic            m_valid_reg, m_valid_next;
    logic            out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == tcw_pkg::ST_IDLE) && out_free;
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            tcw_pkg::ST_INIT: begin
                cmd.fill      = 1'b1;
                cmd.fill_init = 1'b1;
                if (st.fill_last) begin
                    state_next = tcw_pkg::ST_IDLE;
                end
            end
            tcw_pkg::ST_IDLE: begin
                if (s_valid && out_free) begin
                    cmd.accept = 1'b1;
                    if (st.op_clear) begin
                        state_next = tcw_pkg::ST_CLEAR;
                    end else if (st.op_read) begin
                        state_next = tcw_pkg::ST_READ;
                    end else if (st.put_scroll) begin
                        state_next = tcw_pkg::ST_SCROLL;
                    end else begin
                        cmd.load_out = 1'b1;
                    end
                end
            end
            tcw_pkg::ST_READ: begin
                cmd.load_out = 1'b1;
                cmd.out_read = 1'b1;
                state_next   = tcw_pkg::ST_IDLE;
            end
            tcw_pkg::ST_SCROLL: begin
                cmd.scroll = 1'b1;
                if (st.scroll_last) begin
                    cmd.load_out     = 1'b1;
                    cmd.out_scrolled = 1'b1;
                    state_next       = tcw_pkg::ST_IDLE;
                end
            end
            tcw_pkg::ST_CLEAR: begin
                cmd.fill = 1'b1;
                if (st.fill_last) begin
                    cmd.load_out = 1'b1;
                    state_next   = tcw_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tcw_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid_next = (m_valid_reg && !m_ready) || cmd.load_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tcw_pkg::ST_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // a result is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten");

    // a read transaction passes through ST_READ before its result is presented
    a_read_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && st.op_read) |=> (state_reg == tcw_pkg::ST_READ) ##1 m_valid_reg)
        else $error("read result not presented");

    // no result during the reset blanking pass
    a_init_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tcw_pkg::ST_INIT) |-> !m_valid_reg)
        else $error("result during reset pass");

    // a scroll transaction never completes in the following cycle
    a_scroll_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !st.op_clear && !st.op_read && st.put_scroll)
        |=> !s_ready)
        else $error("accepted during scroll");

endmodule

// ----- rtl/tcw_dp.sv -----
// ----------------------------------------------------------------------------
// tcw_dp
// Datapath: configuration registers, cursor, screen memory, sweep pointers
// and result register.
// ----------------------------------------------------------------------------
module tcw_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [tcw_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic [1:0]                           s_opcode,
    input  logic [tcw_pkg::CHAR_W-1:0]           s_char_code,
    input  logic                                 s_to_error_stream,
    input  logic [tcw_pkg::IDX_W-1:0]            s_cell_index,
    output logic [tcw_pkg::CHAR_W-1:0]           m_cell_char,
    output logic [tcw_pkg::ATTR_W-1:0]           m_cell_attr,
    output logic [tcw_pkg::IDX_W-1:0]            m_cursor_index,
    output logic                                 m_scrolled,
    input  tcw_pkg::cmd_t                        cmd,
    output tcw_pkg::status_t                     st
);

    // configuration
    logic [tcw_pkg::COLS_W-1:0] columns_reg;
    logic [tcw_pkg::ROWS_W-1:0] rows_reg;
    logic [tcw_pkg::ATTR_W-1:0] normal_attr_reg, error_attr_reg;

    // cursor: row_base_reg tracks row * width so no multiply is needed
    logic [tcw_pkg::ROWS_W-1:0] row_reg, row_next;
    logic [tcw_pkg::COLS_W-1:0] col_reg, col_next;
    logic [tcw_pkg::IDX_W-1:0]  row_base_reg, row_base_next;

    // sweeps
    logic [tcw_pkg::IDX_W-1:0]  sc_ptr_reg;
    logic                       sc_live_reg;
    logic                       d_valid_reg;
    logic [tcw_pkg::IDX_W-1:0]  d_addr_reg;
    logic                       d_copy_reg;
    logic [tcw_pkg::ATTR_W-1:0] scr_attr_reg;
    logic                       rd_ok_reg;

    // screen memory
    logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::CELL_COUNT];
    logic [tcw_pkg::CELL_W-1:0] rd_data_reg;
    logic                       mem_we, mem_re;
    logic [tcw_pkg::IDX_W-1:0]  mem_wa, mem_ra;
    logic [tcw_pkg::CELL_W-1:0] mem_wd;

    logic [tcw_pkg::COLS_W-1:0] w;
    logic [tcw_pkg::ROWS_W-1:0] h;
    logic [tcw_pkg::AREA_W-1:0] area_wide;
    logic [tcw_pkg::IDX_W-1:0]  area, area_last, cur_lin, wd_ext;
    logic [tcw_pkg::COLS_W:0]   col_inc;
    logic [tcw_pkg::ROWS_W:0]   row_inc;
    logic                       col_wrap, row_wrap;
    logic                       is_put, is_cr, is_lf, is_store, next_row;
    logic [tcw_pkg::ATTR_W-1:0] put_attr, fill_attr;
    logic                       sc_copy;

    // geometry in use, clamped
    always_comb begin
        if (columns_reg == '0) begin
            w = tcw_pkg::COLS_W'(1);
        end else if (columns_reg > tcw_pkg::COLS_W'(tcw_pkg::MAX_COLUMNS)) begin
            w = tcw_pkg::COLS_W'(tcw_pkg::MAX_COLUMNS);
        end else begin
            w = columns_reg;
        end
        if (rows_reg == '0) begin
            h = tcw_pkg::ROWS_W'(1);
        end else if (rows_reg > tcw_pkg::ROWS_W'(tcw_pkg::MAX_ROWS)) begin
            h = tcw_pkg::ROWS_W'(tcw_pkg::MAX_ROWS);
        end else begin
            h = rows_reg;
        end
    end

    assign area_wide = tcw_pkg::AREA_W'(w) * tcw_pkg::AREA_W'(h);
    assign area      = area_wide[tcw_pkg::IDX_W-1:0];
    assign area_last = area - tcw_pkg::IDX_W'(1);
    assign wd_ext    = tcw_pkg::IDX_W'(w);
    assign cur_lin   = row_base_reg + tcw_pkg::IDX_W'(col_reg);

    // put decode
    assign is_put   = (s_opcode == tcw_pkg::OP_PUT);
    assign is_cr    = (s_char_code == tcw_pkg::CH_CR);
    assign is_lf    = (s_char_code == tcw_pkg::CH_LF);
    assign is_store = is_put && !is_cr && !is_lf;
    assign col_inc  = {1'b0, col_reg} + (tcw_pkg::COLS_W+1)'(1);
    assign row_inc  = {1'b0, row_reg} + (tcw_pkg::ROWS_W+1)'(1);
    assign col_wrap = (col_inc >= {1'b0, w});
    assign row_wrap = (row_inc >= {1'b0, h});
    assign next_row = is_lf || (!is_cr && col_wrap);
    assign put_attr = s_to_error_stream ? error_attr_reg : normal_attr_reg;
    assign fill_attr = cmd.fill_init ? tcw_pkg::RST_NORMAL_ATTR : normal_attr_reg;
    assign sc_copy  = (sc_ptr_reg < row_base_reg);

    assign st.op_clear    = (s_opcode == tcw_pkg::OP_CLEAR);
    assign st.op_read     = (s_opcode == tcw_pkg::OP_READ);
    assign st.put_scroll  = is_put && next_row && row_wrap;
    assign st.fill_last   = (sc_ptr_reg == tcw_pkg::IDX_W'(tcw_pkg::CELL_COUNT - 1));
    assign st.scroll_last = d_valid_reg && (d_addr_reg == area_last);

    // cursor next state
    always_comb begin
        row_next      = row_reg;
        col_next      = col_reg;
        row_base_next = row_base_reg;
        if (cfg_wr_en && (cfg_index == tcw_pkg::REG_COLUMNS
                          || cfg_index == tcw_pkg::REG_ROWS)) begin
            row_next      = '0;
            col_next      = '0;
            row_base_next = '0;
        end else if (cmd.accept && st.op_clear) begin
            row_next      = '0;
            col_next      = '0;
            row_base_next = '0;
        end else if (cmd.accept && is_put) begin
            if (is_cr) begin
                col_next = '0;
            end else if (next_row) begin
                col_next = '0;
                // on a scroll the cursor stays on the bottom row
                if (!row_wrap) begin
                    row_next      = row_inc[tcw_pkg::ROWS_W-1:0];
                    row_base_next = row_base_reg + wd_ext;
                end
            end else begin
                col_next = col_inc[tcw_pkg::COLS_W-1:0];
            end
        end
    end

    // memory port selection
    always_comb begin
        mem_we = 1'b0;
        mem_wa = cur_lin;
        mem_wd = {put_attr, s_char_code};
        mem_re = 1'b0;
        mem_ra = sc_ptr_reg + wd_ext;
        if (cmd.accept && is_store) begin
            mem_we = 1'b1;
        end
        if (cmd.accept && st.op_read) begin
            mem_re = 1'b1;
            mem_ra = (s_cell_index < tcw_pkg::IDX_W'(tcw_pkg::CELL_COUNT)) ? s_cell_index : '0;
        end
        if (cmd.fill) begin
            mem_we = 1'b1;
            mem_wa = sc_ptr_reg;
            mem_wd = {fill_attr, tcw_pkg::CH_SPACE};
        end
        if (cmd.scroll) begin
            mem_re = sc_live_reg && sc_copy;
            mem_we = d_valid_reg;
            mem_wa = d_addr_reg;
            mem_wd = d_copy_reg ? rd_data_reg : {scr_attr_reg, tcw_pkg::CH_SPACE};
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            columns_reg     <= tcw_pkg::RST_COLUMNS;
            rows_reg        <= tcw_pkg::RST_ROWS;
            normal_attr_reg <= tcw_pkg::RST_NORMAL_ATTR;
            error_attr_reg  <= tcw_pkg::RST_ERROR_ATTR;
            row_reg         <= '0;
            col_reg         <= '0;
            row_base_reg    <= '0;
            sc_ptr_reg      <= '0;
            sc_live_reg     <= 1'b0;
            d_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    tcw_pkg::REG_COLUMNS:     columns_reg     <= cfg_wdata[tcw_pkg::COLS_W-1:0];
                    tcw_pkg::REG_ROWS:        rows_reg        <= cfg_wdata[tcw_pkg::ROWS_W-1:0];
                    tcw_pkg::REG_NORMAL_ATTR: normal_attr_reg <= cfg_wdata[tcw_pkg::ATTR_W-1:0];
                    tcw_pkg::REG_ERROR_ATTR:  error_attr_reg  <= cfg_wdata[tcw_pkg::ATTR_W-1:0];
                    default: begin
                    end
                endcase
            end
            row_reg      <= row_next;
            col_reg      <= col_next;
            row_base_reg <= row_base_next;
            if (cmd.accept) begin
                sc_ptr_reg  <= '0;
                sc_live_reg <= 1'b1;
                d_valid_reg <= 1'b0;
            end else if (cmd.fill) begin
                sc_ptr_reg <= sc_ptr_reg + tcw_pkg::IDX_W'(1);
            end else if (cmd.scroll) begin
                d_valid_reg <= sc_live_reg;
                if (sc_live_reg) begin
                    sc_ptr_reg  <= sc_ptr_reg + tcw_pkg::IDX_W'(1);
                    sc_live_reg <= (sc_ptr_reg != area_last);
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            scr_attr_reg <= put_attr;
            rd_ok_reg    <= (s_cell_index < area);
        end
        if (cmd.scroll && sc_live_reg) begin
            d_addr_reg <= sc_ptr_reg;
            d_copy_reg <= sc_copy;
        end
        if (cmd.load_out) begin
            if (cmd.out_read && rd_ok_reg) begin
                m_cell_char <= rd_data_reg[tcw_pkg::CHAR_W-1:0];
                m_cell_attr <= rd_data_reg[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
            end else begin
                m_cell_char <= '0;
                m_cell_attr <= '0;
            end
            m_cursor_index <= row_base_next + tcw_pkg::IDX_W'(col_next);
            m_scrolled     <= cmd.out_scrolled;
        end
    end

endmodule
